@@ rtl/i2crts_pkg.sv @@
// Package: shared types and codes for the I2C read transaction sequencer.
`default_nettype none

package i2crts_pkg;

  // input function codes
  localparam logic FN_START = 1'b0;
  localparam logic FN_EVENT = 1'b1;

  // result kinds
  localparam logic [1:0] KD_WRITE = 2'd0;
  localparam logic [1:0] KD_DATA  = 2'd1;
  localparam logic [1:0] KD_DONE  = 2'd2;

  // controller register indexes
  localparam logic [2:0] RG_MODE = 3'd0;
  localparam logic [2:0] RG_CTRL = 3'd1;
  localparam logic [2:0] RG_STAT = 3'd2;
  localparam logic [2:0] RG_ISR  = 3'd3;
  localparam logic [2:0] RG_ADDR = 3'd5;
  localparam logic [2:0] RG_SUB  = 3'd6;
  localparam logic [2:0] RG_DATA = 3'd7;

  // result codes
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_TIMEOUT = 3'd1;
  localparam logic [2:0] RC_NACK    = 3'd2;
  localparam logic [2:0] RC_STEPS   = 3'd3;
  localparam logic [2:0] RC_SHORT   = 3'd4;

  // transfer modes
  localparam logic [1:0] XM_STD_SUB  = 2'd2;
  localparam logic [1:0] XM_COMBINED = 2'd3;

  // interrupt flag bits
  localparam int unsigned IF_DATA = 0;
  localparam int unsigned IF_ADDR = 1;
  localparam int unsigned IF_STOP = 2;

  // status bit: last acknowledge
  localparam int unsigned ST_ACK = 1;

  // control register values
  localparam logic [7:0] CTL_CLEAR = 8'h00;
  localparam logic [7:0] CTL_AAK   = 8'h01;
  localparam logic [7:0] CTL_XADDR = 8'h02;
  localparam logic [7:0] CTL_STOP  = 8'h04;

  localparam logic [6:0] MAX_STEPS = 7'd64;

  // most results one input item can cause
  localparam int unsigned MAX_RES = 6;

  typedef struct packed {
    logic       func;
    logic [6:0] dev_addr;
    logic [7:0] sub_addr;
    logic [7:0] byte_count;
    logic [1:0] xfer_mode;
    logic [3:0] channel;
    logic [3:0] isr_flags;
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_index;
    logic [7:0] reg_value;
    logic [2:0] result_code;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/i2crts_if.sv @@
// Interfaces: valid/ready channels for input items and result items.
`default_nettype none

interface i2crts_in_if import i2crts_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2crts_out_if import i2crts_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/i2c_read_transaction_sequencer_core.sv @@
// Top level: I2C combined-read sequencer, register writes and data bytes per item.
//
//   channel   dir   handshake            payload
//   in_ch     in    valid/ready          in_item_t  (start or interrupt event)
//   out_ch    out   valid/ready          out_item_t (write, data byte or done)
//
// An accepted item is held in the input register; from there its whole result
// list (0 to 6 entries) is built and loaded into the result buffer once that is
// free; it sends one result per cycle while out_ch is ready. A new list can load
// as the last result leaves, so the single-entry output port of the buffer paces items.
// rst_n is synchronous; it returns the sequencer to idle and empties both stages.
// A stalled out_ch holds the buffer; in_ch keeps taking one item into the input
// register meanwhile.
`default_nettype none

module i2c_read_transaction_sequencer_core import i2crts_pkg::*; (
  input  wire            clk,
  input  wire            rst_n,
  i2crts_in_if.sink      in_ch,
  i2crts_out_if.source   out_ch
);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ADDR = 4'b0010,
    PH_READ = 4'b0100,
    PH_STOP = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_index;
    logic [7:0] reg_value;
    logic [2:0] result_code;
  } ent_t;

  function automatic ent_t mk_ent(logic [1:0] k, logic [2:0] r, logic [7:0] v,
                                  logic [2:0] c);
    ent_t e;
    e.kind        = k;
    e.reg_index   = r;
    e.reg_value   = v;
    e.result_code = c;
    return e;
  endfunction

  // input register
  logic     ivld_r;
  in_item_t in_r;

  // sequencer state
  phase_t     phase_r, phase_nxt;
  logic [7:0] bl_r, bl_nxt;
  logic [6:0] sc_r, sc_nxt;
  logic [2:0] pr_r, pr_nxt;

  // result buffer
  logic       obusy_r;
  ent_t       lst_r [MAX_RES];
  logic [2:0] cnt_r;
  logic [2:0] pos_r;

  ent_t       ent [MAX_RES];
  logic [2:0] n;
  logic [2:0] fin_code;
  logic       is_last;
  logic       out_xfer;
  logic       can_load;
  logic       load;

  assign is_last  = (pos_r == cnt_r - 3'd1);
  assign out_xfer = obusy_r && out_ch.ready;
  assign can_load = !obusy_r || (out_xfer && is_last);
  assign load     = ivld_r && can_load;
  assign in_ch.ready = !ivld_r || can_load;

  assign out_ch.valid               = obusy_r;
  assign out_ch.payload.kind        = lst_r[pos_r].kind;
  assign out_ch.payload.reg_index   = lst_r[pos_r].reg_index;
  assign out_ch.payload.reg_value   = lst_r[pos_r].reg_value;
  assign out_ch.payload.result_code = lst_r[pos_r].result_code;
  assign out_ch.payload.last        = is_last;

  // build the result list and next state for the item in the input register
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      ent[i] = mk_ent(KD_WRITE, RG_MODE, 8'h00, RC_OK);
    end
    n         = 3'd0;
    fin_code  = RC_OK;
    phase_nxt = phase_r;
    bl_nxt    = bl_r;
    sc_nxt    = sc_r;
    pr_nxt    = pr_r;

    if (in_r.func == FN_START) begin
      ent[n] = mk_ent(KD_WRITE, RG_ISR, {4'h0, in_r.isr_flags}, RC_OK);
      n = n + 3'd1;
      ent[n] = mk_ent(KD_WRITE, RG_MODE, {in_r.channel, in_r.xfer_mode, 2'b00}, RC_OK);
      n = n + 3'd1;
      ent[n] = mk_ent(KD_WRITE, RG_STAT, 8'h00, RC_OK);
      n = n + 3'd1;
      ent[n] = mk_ent(KD_WRITE, RG_ADDR, {in_r.dev_addr, 1'b1}, RC_OK);
      n = n + 3'd1;
      if (in_r.xfer_mode == XM_STD_SUB || in_r.xfer_mode == XM_COMBINED) begin
        ent[n] = mk_ent(KD_WRITE, RG_SUB, in_r.sub_addr, RC_OK);
        n = n + 3'd1;
      end
      ent[n] = mk_ent(KD_WRITE, RG_CTRL, CTL_XADDR, RC_OK);
      n = n + 3'd1;
      phase_nxt = PH_ADDR;
      bl_nxt    = in_r.byte_count;
      sc_nxt    = 7'd0;
      pr_nxt    = RC_OK;
    end else if (phase_r != PH_IDLE) begin
      if (in_r.isr_flags == 4'h0) begin
        ent[n] = mk_ent(KD_DONE, RG_MODE, 8'h00, RC_TIMEOUT);
        n = n + 3'd1;
        phase_nxt = PH_IDLE;
        sc_nxt    = 7'd0;
        pr_nxt    = RC_OK;
      end else begin
        if (in_r.isr_flags[IF_ADDR]) begin
          if (!in_r.status_byte[ST_ACK]) begin
            ent[n] = mk_ent(KD_WRITE, RG_CTRL, CTL_STOP, RC_OK);
            n = n + 3'd1;
            phase_nxt = PH_STOP;
            pr_nxt    = RC_NACK;
          end else begin
            phase_nxt = PH_READ;
            if (bl_r > 8'd1) begin
              ent[n] = mk_ent(KD_WRITE, RG_CTRL, CTL_AAK, RC_OK);
              n = n + 3'd1;
            end
          end
        end
        if (in_r.isr_flags[IF_DATA] && phase_nxt == PH_READ) begin
          if (bl_nxt != 8'd0) begin
            ent[n] = mk_ent(KD_DATA, RG_DATA, in_r.data_byte, RC_OK);
            n = n + 3'd1;
            bl_nxt = bl_nxt - 8'd1;
          end
          if (bl_nxt == 8'd1) begin
            ent[n] = mk_ent(KD_WRITE, RG_CTRL, CTL_CLEAR, RC_OK);
            n = n + 3'd1;
          end else if (bl_nxt == 8'd0) begin
            phase_nxt = PH_STOP;
          end
        end
        ent[n] = mk_ent(KD_WRITE, RG_ISR, {4'h0, in_r.isr_flags}, RC_OK);
        n = n + 3'd1;
        if (in_r.isr_flags[IF_STOP] || sc_r >= MAX_STEPS) begin
          if (in_r.isr_flags[IF_STOP]) begin
            fin_code = pr_nxt;
            if (fin_code == RC_OK && bl_nxt != 8'd0) begin
              fin_code = RC_SHORT;
            end
          end else begin
            fin_code = RC_STEPS;
          end
          ent[n] = mk_ent(KD_DONE, RG_MODE, 8'h00, fin_code);
          n = n + 3'd1;
          phase_nxt = PH_IDLE;
          sc_nxt    = 7'd0;
          pr_nxt    = RC_OK;
        end else begin
          sc_nxt = sc_r + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r  <= 1'b0;
      obusy_r <= 1'b0;
      cnt_r   <= 3'd0;
      pos_r   <= 3'd0;
      phase_r <= PH_IDLE;
      bl_r    <= 8'd0;
      sc_r    <= 7'd0;
      pr_r    <= RC_OK;
    end else begin
      if (in_ch.ready) begin
        ivld_r <= in_ch.valid;
      end
      if (out_xfer) begin
        if (is_last) begin
          // a new list loaded on the same edge keeps the buffer busy
          if (!(load && n != 3'd0)) begin
            obusy_r <= 1'b0;
          end
        end else begin
          pos_r <= pos_r + 3'd1;
        end
      end
      if (load) begin
        phase_r <= phase_nxt;
        bl_r    <= bl_nxt;
        sc_r    <= sc_nxt;
        pr_r    <= pr_nxt;
        if (n != 3'd0) begin
          obusy_r <= 1'b1;
          cnt_r   <= n;
          pos_r   <= 3'd0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r <= in_ch.payload;
    end
    if (load && n != 3'd0) begin
      for (int i = 0; i < MAX_RES; i++) begin
        lst_r[i] <= ent[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/i2crts_chk.sv @@
// Checker: port-level assertions on the sequencer's result channel, with its bind.
`default_nettype none

module i2crts_chk import i2crts_pkg::*; (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input out_item_t out_payload
);

  // result buffer is empty right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed");

  // done always closes the item's result list
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.kind == KD_DONE |-> out_payload.last)
    else $error("done result without last");

  // received bytes come from the data register and carry no code
  a_data_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.kind == KD_DATA |->
      out_payload.reg_index == RG_DATA && out_payload.result_code == RC_OK)
    else $error("data result with wrong index or code");

  // only done carries a result code
  a_code_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.kind == KD_WRITE |-> out_payload.result_code == RC_OK)
    else $error("register write with result code");

endmodule

bind i2c_read_transaction_sequencer_core i2crts_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

`default_nettype wire
